@@ hdl/hkct_pkg.sv @@
// Shared constants, codes and types of the key counting table.
`default_nettype none
package hkct_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int COUNT_BITS    = 40;
    localparam int KEY_BITS      = 64;
    localparam int LEN_BITS      = 20;
    localparam int AB_BITS       = 32;
    localparam int OCC_BITS      = 13;
    localparam int SUM_BITS      = 48;
    localparam int STATUS_BITS   = 4;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 40;
    localparam int UNIQUE_BITS   = 40;

    // A miss may insert while occupied entries stay below this count.
    localparam int FILL_LIMIT = (95 * TABLE_ENTRIES) / 100;

    localparam int S_DATA_BITS = 312;
    localparam int M_DATA_BITS = 160;

    localparam logic [STATUS_BITS-1:0] ST_SHORT     = 4'd0;
    localparam logic [STATUS_BITS-1:0] ST_LONG      = 4'd1;
    localparam logic [STATUS_BITS-1:0] ST_NEW       = 4'd2;
    localparam logic [STATUS_BITS-1:0] ST_ADDED     = 4'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 4'd4;
    localparam logic [STATUS_BITS-1:0] ST_SELECTED  = 4'd5;
    localparam logic [STATUS_BITS-1:0] ST_OUT_RANGE = 4'd6;
    localparam logic [STATUS_BITS-1:0] ST_EMITTED   = 4'd7;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 4'd8;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_BOTH_STRANDS  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_USE_ABUNDANCE = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MIN_LENGTH    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_LENGTH    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MIN_UNIQUE    = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_UNIQUE    = 3'd5;

    typedef struct packed {
        logic                  emitted;
        logic [COUNT_BITS-1:0] count;
        logic [KEY_BITS-1:0]   key_second;
        logic [KEY_BITS-1:0]   key_first;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

endpackage
`default_nettype wire

@@ hdl/hash_key_count_table.sv @@
// Key counting table: linear-probing hash table of 128-bit keys with counts.
//
// Input transactions arrive on s_tvalid/s_tready/s_tdata/s_tuser (s_tuser is
// the op: 0 count, 1 select). Every input transaction gives exactly one
// result transaction on m_tvalid/m_tready/m_tdata. The user must write
// registers through cfg_wr_en/cfg_addr/cfg_wr_data only while the block is idle; the block does not enforce this.
//
// After reset the block sweeps the whole table, one entry per cycle, and
// holds s_tready low until the sweep is done.
//
// Items are handled one at a time by a single table read port and one
// key comparator. Each probed slot takes a read step and a compare step.
// An item that the length filter rejects goes straight to the output
// step; any other item probes 1 to TABLE_ENTRIES slots per strand, then
// passes through update and finish steps. s_tready is high only while idle.
//
// The result sits in an output register; a stalled receiver does not
// block acceptance of the next item, but the finished item waits for the
// output register to empty before the block returns to idle.
`default_nettype none
module hash_key_count_table (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // key_first, key_second, rev_key_first, rev_key_second, seq_length,
    // abundance (lowest bits first), zero-filled to 312 bits
    input  wire logic [hkct_pkg::S_DATA_BITS-1:0]     s_tdata,
    // op
    input  wire logic                                 s_tuser,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // status, entry_count, distinct_keys, largest_count, total_count,
    // selected_ordinal (lowest bits first), zero-filled to 160 bits
    output logic      [hkct_pkg::M_DATA_BITS-1:0]     m_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [hkct_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire logic [hkct_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data
);
    import hkct_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD, S_CHK, S_UPD, S_FIN, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic                   both_strands_reg, use_abundance_reg;
    logic [LEN_BITS-1:0]    min_length_reg, max_length_reg;
    logic [UNIQUE_BITS-1:0] min_unique_reg, max_unique_reg;

    // current item
    logic                   op_reg;
    logic [KEY_BITS-1:0]    k1_reg, k2_reg, r1_reg, r2_reg;
    logic [AB_BITS-1:0]     ab_reg;

    // probe sequencer
    logic                   rev_phase_reg;
    logic [IDX_BITS-1:0]    idx_reg;
    logic [IDX_BITS:0]      steps_reg;
    logic                   hit_reg, free_reg;
    logic [IDX_BITS-1:0]    slot_reg;
    entry_t                 entry_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [COUNT_BITS-1:0]  newcount_reg;
    logic [OCC_BITS-1:0]    ord_reg;

    // statistics
    logic [OCC_BITS-1:0]    occ_reg, sel_reg;
    logic [COUNT_BITS-1:0]  max_reg;
    logic [SUM_BITS-1:0]    sum_reg;

    // output register
    logic [M_DATA_BITS-1:0] m_tdata_reg;
    logic                   m_tvalid_reg;

    // table port
    entry_t                 rd_entry, wr_entry;
    logic                   ram_we;
    logic [IDX_BITS-1:0]    ram_waddr;

    // combinational helpers
    logic [KEY_BITS-1:0]    cur_k1, cur_k2;
    logic                   key_match, slot_empty, last_step;
    logic [AB_BITS-1:0]     weight;
    logic [COUNT_BITS:0]    add_sum;
    logic [COUNT_BITS-1:0]  add_sat, new_sat;
    logic [SUM_BITS:0]      tot_sum;
    logic                   do_write;

    logic [KEY_BITS-1:0]    in_k1, in_k2, in_r1, in_r2;
    logic [LEN_BITS-1:0]    in_len;
    logic [AB_BITS-1:0]     in_ab;

    assign in_k1  = s_tdata[63:0];
    assign in_k2  = s_tdata[127:64];
    assign in_r1  = s_tdata[191:128];
    assign in_r2  = s_tdata[255:192];
    assign in_len = s_tdata[275:256];
    assign in_ab  = s_tdata[307:276];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    assign cur_k1     = rev_phase_reg ? r1_reg : k1_reg;
    assign cur_k2     = rev_phase_reg ? r2_reg : k2_reg;
    assign slot_empty = (rd_entry.count == '0);
    assign key_match  = (rd_entry.key_first == cur_k1) && (rd_entry.key_second == cur_k2);
    assign last_step  = (steps_reg == (IDX_BITS+1)'(TABLE_ENTRIES - 1));

    assign weight  = (use_abundance_reg && ab_reg != '0) ? ab_reg : AB_BITS'(1);
    assign add_sum = {1'b0, entry_reg.count} + (COUNT_BITS+1)'(weight);
    assign add_sat = add_sum[COUNT_BITS] ? '1 : add_sum[COUNT_BITS-1:0];
    assign new_sat = COUNT_BITS'(weight);
    assign tot_sum = {1'b0, sum_reg} + (SUM_BITS+1)'(weight);

    assign do_write = (status_reg == ST_ADDED) || (status_reg == ST_NEW) ||
                      (status_reg == ST_SELECTED) || (status_reg == ST_OUT_RANGE);

    always_comb begin
        wr_entry = entry_reg;
        case (status_reg)
            ST_NEW: begin
                wr_entry.key_first  = k1_reg;
                wr_entry.key_second = k2_reg;
                wr_entry.count      = newcount_reg;
                wr_entry.emitted    = 1'b0;
            end
            ST_ADDED: wr_entry.count = newcount_reg;
            default:  wr_entry.emitted = 1'b1;
        endcase
        if (state_reg == S_CLEAR) begin
            wr_entry = '0;
        end
    end

    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_FIN && do_write);
    assign ram_waddr = (state_reg == S_CLEAR) ? idx_reg : slot_reg;

    hkct_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (wr_entry),
        .rd_addr (idx_reg),
        .rd_data (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            both_strands_reg  <= 1'b0;
            use_abundance_reg <= 1'b0;
            min_length_reg    <= LEN_BITS'(32);
            max_length_reg    <= LEN_BITS'(50000);
            min_unique_reg    <= UNIQUE_BITS'(1);
            max_unique_reg    <= '1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_BOTH_STRANDS:  both_strands_reg  <= cfg_wr_data[0];
                CFG_USE_ABUNDANCE: use_abundance_reg <= cfg_wr_data[0];
                CFG_MIN_LENGTH:    min_length_reg    <= cfg_wr_data[LEN_BITS-1:0];
                CFG_MAX_LENGTH:    max_length_reg    <= cfg_wr_data[LEN_BITS-1:0];
                CFG_MIN_UNIQUE:    min_unique_reg    <= cfg_wr_data[UNIQUE_BITS-1:0];
                CFG_MAX_UNIQUE:    max_unique_reg    <= cfg_wr_data[UNIQUE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            occ_reg      <= '0;
            sel_reg      <= '0;
            max_reg      <= '0;
            sum_reg      <= '0;
        end else begin
            // S_OUT reloads the output register on its own
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == '1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg        <= s_tuser;
                        k1_reg        <= in_k1;
                        k2_reg        <= in_k2;
                        r1_reg        <= in_r1;
                        r2_reg        <= in_r2;
                        ab_reg        <= in_ab;
                        newcount_reg  <= '0;
                        ord_reg       <= '0;
                        rev_phase_reg <= 1'b0;
                        idx_reg       <= in_k1[IDX_BITS-1:0];
                        steps_reg     <= '0;
                        if (in_len < min_length_reg) begin
                            status_reg <= ST_SHORT;
                            state_reg  <= S_OUT;
                        end else if (in_len > max_length_reg) begin
                            status_reg <= ST_LONG;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD: state_reg <= S_CHK;
                S_CHK: begin
                    if (slot_empty || key_match || last_step) begin
                        // probe of this strand ends here
                        if (!rev_phase_reg) begin
                            hit_reg   <= !slot_empty && key_match;
                            free_reg  <= slot_empty;
                            slot_reg  <= (slot_empty || key_match) ? idx_reg : '0;
                            entry_reg <= rd_entry;
                            if (!(!slot_empty && key_match) && both_strands_reg) begin
                                rev_phase_reg <= 1'b1;
                                idx_reg       <= r1_reg[IDX_BITS-1:0];
                                steps_reg     <= '0;
                                state_reg     <= S_RD;
                            end else begin
                                state_reg <= S_UPD;
                            end
                        end else begin
                            if (!slot_empty && key_match) begin
                                hit_reg   <= 1'b1;
                                slot_reg  <= idx_reg;
                                entry_reg <= rd_entry;
                            end
                            state_reg <= S_UPD;
                        end
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_UPD: begin
                    if (!op_reg) begin
                        if (hit_reg) begin
                            status_reg   <= ST_ADDED;
                            newcount_reg <= add_sat;
                        end else if (!free_reg || occ_reg >= OCC_BITS'(FILL_LIMIT)) begin
                            status_reg <= ST_FULL;
                        end else begin
                            status_reg   <= ST_NEW;
                            newcount_reg <= new_sat;
                        end
                    end else begin
                        if (!hit_reg) begin
                            status_reg <= ST_NOT_FOUND;
                        end else begin
                            newcount_reg <= entry_reg.count;
                            if (entry_reg.emitted) begin
                                status_reg <= ST_EMITTED;
                            end else if (entry_reg.count >= min_unique_reg &&
                                         entry_reg.count <= max_unique_reg) begin
                                status_reg <= ST_SELECTED;
                            end else begin
                                status_reg <= ST_OUT_RANGE;
                            end
                        end
                    end
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (status_reg == ST_ADDED || status_reg == ST_NEW) begin
                        if (status_reg == ST_NEW) begin
                            occ_reg <= occ_reg + 1'b1;
                        end
                        sum_reg <= tot_sum[SUM_BITS] ? '1 : tot_sum[SUM_BITS-1:0];
                        if (newcount_reg > max_reg) begin
                            max_reg <= newcount_reg;
                        end
                    end
                    if (status_reg == ST_SELECTED) begin
                        if (sel_reg != '1) begin
                            sel_reg <= sel_reg + 1'b1;
                            ord_reg <= sel_reg + 1'b1;
                        end else begin
                            ord_reg <= sel_reg;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {2'b00, ord_reg, sum_reg, max_reg, occ_reg,
                                         newcount_reg, status_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_while_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("input accepted during table clear");

    a_fill_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_BITS'(FILL_LIMIT))
        else $error("occupancy above fill cap");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while busy");

    a_write_when_allowed: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_FIN))
        else $error("table written outside clear or finish");

endmodule
`default_nettype wire

@@ hdl/hkct_ram.sv @@
// Single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hkct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

@@ bench/hash_key_count_table_test.sv @@
// Self-checking testbench of the key counting table: predicts every result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module hash_key_count_table_test;
    import hkct_pkg::*;

    localparam logic [39:0] COUNT_TOP = {COUNT_BITS{1'b1}};
    localparam logic [47:0] SUM_TOP   = {SUM_BITS{1'b1}};
    localparam int STALL_LIMIT = 100000;

    typedef struct packed {
        logic [12:0] selected_ordinal;
        logic [47:0] total_count;
        logic [39:0] largest_count;
        logic [12:0] distinct_keys;
        logic [39:0] entry_count;
        logic [3:0]  status;
    } tally_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [S_DATA_BITS-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [M_DATA_BITS-1:0] m_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data = '0;

    hash_key_count_table u_top (.*);

    always #5 aclk = ~aclk;

    // shadow of the table
    logic [63:0] tab_k1 [TABLE_ENTRIES];
    logic [63:0] tab_k2 [TABLE_ENTRIES];
    logic [39:0] tab_cnt [TABLE_ENTRIES];
    logic        tab_emit [TABLE_ENTRIES];
    logic [12:0] occ_total;
    logic [39:0] max_seen;
    logic [47:0] sum_all;
    logic [12:0] sel_total;
    logic        r_both, r_abund;
    logic [19:0] r_min_len, r_max_len;
    logic [39:0] r_min_uni, r_max_uni;

    tally_t expected_tallies[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;
    logic [63:0] key_pool[$];

    // Look up a key; returns hit, slot, and whether an empty slot was met.
    function automatic bit probe_key(input logic [63:0] k1, input logic [63:0] k2,
                                     output int slot, output bit has_free);
        int idx;
        idx = int'(k1[IDX_BITS-1:0]);
        for (int n = 0; n < TABLE_ENTRIES; n++) begin
            if (tab_cnt[idx] == 0) begin
                slot = idx; has_free = 1; return 0;
            end
            if (tab_k1[idx] == k1 && tab_k2[idx] == k2) begin
                slot = idx; has_free = 0; return 1;
            end
            idx = (idx + 1) % TABLE_ENTRIES;
        end
        slot = 0; has_free = 0; return 0;
    endfunction

    function automatic tally_t predict_tally(input bit op, input logic [63:0] k1,
            input logic [63:0] k2, input logic [63:0] r1, input logic [63:0] r2,
            input logic [19:0] len, input logic [31:0] ab);
        tally_t t;
        int slot, rslot;
        bit free_ok, rfree, hit;
        logic [40:0] w, c;
        t = '0;
        if (len < r_min_len) t.status = ST_SHORT;
        else if (len > r_max_len) t.status = ST_LONG;
        else begin
            hit = probe_key(k1, k2, slot, free_ok);
            if (!hit && r_both && probe_key(r1, r2, rslot, rfree)) begin
                hit = 1; slot = rslot;
            end
            if (!op) begin
                w = r_abund ? ab : 1;
                if (w == 0) w = 1;
                if (hit) begin
                    c = tab_cnt[slot] + w;
                    if (c > COUNT_TOP) c = COUNT_TOP;
                    tab_cnt[slot] = c[39:0];
                    t.entry_count = c[39:0];
                    t.status = ST_ADDED;
                end else if (!free_ok || 100 * (occ_total + 1) > 95 * TABLE_ENTRIES) begin
                    t.status = ST_FULL;
                end else begin
                    tab_cnt[slot] = w[39:0];
                    tab_k1[slot] = k1;
                    tab_k2[slot] = k2;
                    tab_emit[slot] = 0;
                    occ_total++;
                    t.entry_count = w[39:0];
                    t.status = ST_NEW;
                end
                if (t.status != ST_FULL) begin
                    sum_all = (sum_all > SUM_TOP - w) ? SUM_TOP : sum_all + w;
                    if (t.entry_count > max_seen) max_seen = t.entry_count;
                end
            end else if (!hit) t.status = ST_NOT_FOUND;
            else begin
                t.entry_count = tab_cnt[slot];
                if (tab_emit[slot]) t.status = ST_EMITTED;
                else begin
                    if (t.entry_count >= r_min_uni && t.entry_count <= r_max_uni) begin
                        if (sel_total < 8191) sel_total++;
                        t.selected_ordinal = sel_total;
                        t.status = ST_SELECTED;
                    end else t.status = ST_OUT_RANGE;
                    tab_emit[slot] = 1;
                end
            end
        end
        t.distinct_keys = occ_total;
        t.largest_count = max_seen;
        t.total_count = sum_all;
        return t;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_BOTH_STRANDS:  r_both = val[0];
            CFG_USE_ABUNDANCE: r_abund = val[0];
            CFG_MIN_LENGTH:    r_min_len = val[19:0];
            CFG_MAX_LENGTH:    r_max_len = val[19:0];
            CFG_MIN_UNIQUE:    r_min_uni = val;
            CFG_MAX_UNIQUE:    r_max_uni = val;
            default: ;
        endcase
    endtask

    // Send one transaction; the expectation is queued at acceptance.
    // tvalid stays high after acceptance until the next idle or drain drops it.
    task automatic send_key(input bit op, input logic [63:0] k1, input logic [63:0] k2,
            input logic [63:0] r1, input logic [63:0] r2, input logic [19:0] len,
            input logic [31:0] ab);
        while (!calm && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {56'd0, ab, len, r2, r1, k2, k1};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_tallies.push_back(predict_tally(op, k1, k2, r1, r2, len, ab));
        @(negedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Keys with a few home slots collide often; the pool makes hits likely.
    function automatic logic [63:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(99) < 60)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        if ($urandom_range(1)) return {$urandom, 20'd0, 4'($urandom_range(15)), 8'd0} |
            ($urandom_range(7) * 64'd4096);
        return rand64();
    endfunction

    task automatic send_random(input int n, input int sel_pct);
        logic [63:0] k;
        logic [19:0] len;
        for (int i = 0; i < n; i++) begin
            k = pick_key();
            if (key_pool.size() < 300) key_pool.push_back(k);
            len = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(100, 32));
            send_key($urandom_range(99) < sel_pct, k, {k[31:0], k[63:32]},
                     pick_key(), {$urandom, $urandom}, len,
                     $urandom_range(3) == 0 ? $urandom : $urandom_range(3));
        end
    endtask

    task automatic test_directed();
        logic [63:0] ones;
        ones = '1;
        send_key(0, 64'd5, 64'd7, 64'd9, 64'd9, 20'd31, 32'd1);
        send_key(0, 64'd5, 64'd7, 64'd9, 64'd9, 20'd50001, 32'd1);
        send_key(1, 64'd5, 64'd7, 64'd9, 64'd9, 20'hFFFFF, 32'd1);
        send_key(1, 64'd5, 64'd7, 64'd9, 64'd9, 20'd40, 32'd1);
        send_key(0, 64'd5, 64'd7, 64'd9, 64'd9, 20'd32, 32'd1);
        send_key(0, 64'd5, 64'd7, 64'd9, 64'd9, 20'd50000, 32'hFFFFFFFF);
        send_key(0, 64'd4101, 64'd1, 64'd9, 64'd9, 20'd40, 32'd0);
        send_key(0, ones, ones, ones, ones, 20'd40, 32'd1);
        send_key(1, 64'd5, 64'd7, 64'd9, 64'd9, 20'd40, 32'd1);
        send_key(1, 64'd5, 64'd7, 64'd9, 64'd9, 20'd40, 32'd1);
        send_key(0, 64'd5, 64'd7, 64'd9, 64'd9, 20'd40, 32'd1);
        send_key(1, 64'd4101, 64'd1, 64'd9, 64'd9, 20'd40, 32'd1);
        send_key(1, ones, ones, ones, ones, 20'd0, 32'd1);
    endtask

    task automatic test_strands_abundance();
        write_reg(CFG_BOTH_STRANDS, 1);
        write_reg(CFG_USE_ABUNDANCE, 1);
        send_key(0, 64'd77, 64'd1, 64'd5, 64'd7, 20'd40, 32'd0);
        send_key(0, 64'd78, 64'd1, 64'd79, 64'd2, 20'd40, 32'hFFFFFFFF);
        send_key(1, 64'd99, 64'd1, 64'd4101, 64'd1, 20'd40, 32'd3);
        // drive one entry up to count saturation
        for (int i = 0; i < 260; i++)
            send_key(0, 64'd300, 64'd300, 64'd0, 64'd0, 20'd40, 32'hFFFFFFFF);
        send_key(1, 64'd300, 64'd300, 64'd0, 64'd0, 20'd40, 32'd1);
        send_random(300, 20);
    endtask

    task automatic test_length_limits();
        write_reg(CFG_MIN_LENGTH, 20'hFFFFF);
        write_reg(CFG_MAX_LENGTH, 0);
        send_random(40, 50);
        write_reg(CFG_MIN_LENGTH, 0);
        write_reg(CFG_MAX_LENGTH, 20'hFFFFF);
        send_key(0, 64'd11, 64'd11, 64'd0, 64'd0, 20'd0, 32'd1);
        send_key(0, 64'd11, 64'd11, 64'd0, 64'd0, 20'hFFFFF, 32'd1);
        write_reg(CFG_MIN_LENGTH, 32);
        write_reg(CFG_MAX_LENGTH, 100);
    endtask

    task automatic test_select_range();
        write_reg(CFG_MIN_UNIQUE, 2);
        write_reg(CFG_MAX_UNIQUE, 1000);
        write_reg(CFG_USE_ABUNDANCE, 0);
        send_random(300, 40);
        write_reg(CFG_MIN_UNIQUE, COUNT_TOP);
        write_reg(CFG_MAX_UNIQUE, 0);
        send_random(100, 50);
        write_reg(CFG_MIN_UNIQUE, 0);
        write_reg(CFG_MAX_UNIQUE, COUNT_TOP);
        write_reg(CFG_BOTH_STRANDS, 0);
        calm = 1'b1;
        send_random(200, 30);
        calm = 1'b0;
    endtask

    task automatic test_fill_up();
        // load a batch of fresh keys, then mix lookups over the fuller table
        write_reg(CFG_USE_ABUNDANCE, 1);
        for (int i = 0; i < 300; i++)
            send_key(0, rand64(), rand64(), rand64(), rand64(), 20'd50, $urandom);
        send_random(50, 30);
        write_reg(CFG_BOTH_STRANDS, 1);
        send_random(50, 30);
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        tally_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
        if (m_tvalid && m_tready) begin
            got = m_tdata[$bits(tally_t)-1:0];
            if (expected_tallies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_tallies.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    always @(negedge aclk) m_tready <= calm || ($urandom_range(99) >= 18);

    always @(posedge aclk)
        if (idle_cycles > STALL_LIMIT) begin
            $display("hash_key_count_table: mismatch");
            $finish;
        end

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tab_cnt[i] = 0; tab_emit[i] = 0; tab_k1[i] = 0; tab_k2[i] = 0;
        end
        occ_total = 0; max_seen = 0; sum_all = 0; sel_total = 0;
        r_both = 0; r_abund = 0; r_min_len = 32; r_max_len = 50000;
        r_min_uni = 1; r_max_uni = COUNT_TOP;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_strands_abundance();
        test_length_limits();
        test_select_range();
        test_fill_up();
        wait_drained();
        if (mismatches == 0) $display("hash_key_count_table: match");
        else $display("hash_key_count_table: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
